[rtl/rmts_pkg.sv]
// Shared types and constants for the rate-monotonic task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rmts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int MAX_TASKS_LIM = 64;
    localparam int SLOT_W        = $clog2(MAX_TASKS_LIM);
    localparam int ID_W          = 22;
    localparam int PER_W         = 16;
    localparam int TIME_W        = 32;
    localparam int STAT_W        = 3;

    localparam logic [1:0] OP_REG   = 2'd0;
    localparam logic [1:0] OP_YIELD = 2'd1;
    localparam logic [1:0] OP_DEREG = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MISSED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DUP     = 3'd4;

    localparam logic [1:0] RS_RUN   = 2'd0;
    localparam logic [1:0] RS_READY = 2'd1;
    localparam logic [1:0] RS_SLEEP = 2'd2;

    typedef struct packed {
        logic                valid;
        logic                wake;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   tnew;
        logic [SLOT_W-1:0]   run_slot;
        logic                m_found;
        logic [SLOT_W-1:0]   m_idx;
        logic [PER_W-1:0]    m_per;
        logic [TIME_W-1:0]   m_dl;
        logic                m_hasdl;
        logic                f_found;
        logic [SLOT_W-1:0]   f_idx;
        logic                b_found;
        logic [SLOT_W-1:0]   b_idx;
        logic [PER_W-1:0]    b_per;
        logic [ID_W-1:0]     b_task;
        logic [PER_W-1:0]    r_per;
    } t_tok;

    typedef struct packed {
        logic                reg_en;
        logic                dereg_en;
        logic                dl_en;
        logic                arm_en;
        logic [SLOT_W-1:0]   idx;
        logic [ID_W-1:0]     id;
        logic [PER_W-1:0]    per;
        logic [TIME_W-1:0]   dl;
        logic                run_en;
        logic [SLOT_W-1:0]   run_idx;
        logic                rdy_en;
        logic [SLOT_W-1:0]   rdy_idx;
    } t_wr;

endpackage
`default_nettype wire

[rtl/rmts_cell.sv]
// One task slot of the scheduler chain; folds its entry into the passing scan token.
`timescale 1ns / 1ps
`default_nettype none
module rmts_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  rmts_pkg::t_tok   i_tok,
    input  rmts_pkg::t_wr    i_wr,
    output rmts_pkg::t_tok   o_tok
);
    import rmts_pkg::*;

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

    logic                r_used;
    logic                r_armed;
    logic                r_hasdl;
    logic [ID_W-1:0]     r_task;
    logic [PER_W-1:0]    r_per;
    logic [TIME_W-1:0]   r_dl;
    logic [1:0]          r_st;
    t_tok                r_tok;
    t_tok                n_tok;
    logic                w_wake;
    logic [1:0]          w_st;
    logic                w_match;

    assign w_wake  = i_tok.valid && i_tok.wake && r_used && r_armed && (r_dl <= i_tok.tnew);
    assign w_st    = w_wake ? RS_READY : r_st;
    assign w_match = r_used && (r_task == i_tok.id);

    always_comb begin
        n_tok = i_tok;
        if (w_match && !i_tok.m_found) begin
            n_tok.m_found = 1'b1;
            n_tok.m_idx   = MY_IDX;
            n_tok.m_per   = r_per;
            n_tok.m_dl    = r_dl;
            n_tok.m_hasdl = r_hasdl;
        end
        if (!r_used && !i_tok.f_found) begin
            n_tok.f_found = 1'b1;
            n_tok.f_idx   = MY_IDX;
        end
        if (r_used && (w_st == RS_READY) && (!i_tok.b_found || (r_per < i_tok.b_per))) begin
            n_tok.b_found = 1'b1;
            n_tok.b_idx   = MY_IDX;
            n_tok.b_per   = r_per;
            n_tok.b_task  = r_task;
        end
        if (i_tok.run_slot == MY_IDX) begin
            n_tok.r_per = r_per;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_armed <= 1'b0;
        end else begin
            if (w_wake) begin
                r_armed <= 1'b0;
                r_st    <= RS_READY;
            end
            if (i_wr.reg_en && (i_wr.idx == MY_IDX)) begin
                r_used  <= 1'b1;
                r_armed <= 1'b0;
                r_hasdl <= 1'b0;
                r_task  <= i_wr.id;
                r_per   <= i_wr.per;
                r_dl    <= '0;
                r_st    <= RS_SLEEP;
            end
            if (i_wr.dereg_en && (i_wr.idx == MY_IDX)) begin
                r_used  <= 1'b0;
                r_armed <= 1'b0;
                r_hasdl <= 1'b0;
            end
            if (i_wr.dl_en && (i_wr.idx == MY_IDX)) begin
                r_dl    <= i_wr.dl;
                r_hasdl <= 1'b1;
                if (i_wr.arm_en) begin
                    r_armed <= 1'b1;
                    r_st    <= RS_SLEEP;
                end
            end
            if (i_wr.rdy_en && (i_wr.rdy_idx == MY_IDX)) begin
                r_st <= RS_READY;
            end
            if (i_wr.run_en && (i_wr.run_idx == MY_IDX)) begin
                r_st <= RS_RUN;
            end
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

[rtl/rate_monotonic_task_scheduler.sv]
// Top level of the rate-monotonic task scheduler: command control and slot chain.
//
//  channel | dir | handshake                         | payload
//  s_axis  | in  | s_axis_tvalid / s_axis_tready     | opcode, task_id, period_ms
//  m_axis  | out | m_axis_tvalid / m_axis_tready     | status, running_valid, running_id
//
// A scan token walks the slot chain one cell per cycle; a yield that dispatches
// makes a second walk to pick the next task.
// One command at a time; s_axis_tready is high only when idle.
// A finished response waits in the output register; a stalled m_axis holds it.
// Synchronous active-low reset empties the table and clears the running task.
`timescale 1ns / 1ps
`default_nettype none
module rate_monotonic_task_scheduler #(
    parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // opcode[1:0], task_id[23:2], period_ms[39:24]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // status[2:0], running_valid[3], running_id[25:4]
);
    import rmts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DISP = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    t_tok                w_chain [0:MAX_TASKS];
    t_wr                 w_wr;
    t_tok                r_inj;
    t_tok                n_inj;
    t_tok                w_tail;
    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [1:0]          r_op;
    logic [PER_W-1:0]    r_per_in;
    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   n_time;
    logic                r_run_valid;
    logic                n_run_valid;
    logic [SLOT_W-1:0]   r_run_slot;
    logic [SLOT_W-1:0]   n_run_slot;
    logic [ID_W-1:0]     r_run_id;
    logic [ID_W-1:0]     n_run_id;
    logic [STAT_W-1:0]   r_status;
    logic [STAT_W-1:0]   n_status;
    logic                r_ov;
    logic [31:0]         r_odata;
    logic                w_acc;
    logic [TIME_W-1:0]   w_dl;
    logic                w_missed;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_tail        = w_chain[MAX_TASKS];
    assign w_chain[0]    = r_inj;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            rmts_cell #(.CELL_IDX(g)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_tok  (w_chain[g]),
                .i_wr   (w_wr),
                .o_tok  (w_chain[g+1])
            );
        end
    endgenerate

    assign w_dl     = w_tail.m_hasdl ? (w_tail.m_dl + TIME_W'(w_tail.m_per))
                                     : (r_time + TIME_W'(w_tail.m_per));
    assign w_missed = w_tail.m_hasdl && (r_time > w_dl);

    always_comb begin
        n_state     = r_state;
        n_inj       = '0;
        n_time      = r_time;
        n_run_valid = r_run_valid;
        n_run_slot  = r_run_slot;
        n_run_id    = r_run_id;
        n_status    = r_status;
        w_wr        = '0;
        w_wr.id     = w_tail.id;
        w_wr.per    = r_per_in;
        w_wr.dl     = w_dl;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_inj.valid    = 1'b1;
                    n_inj.wake     = (s_axis_tdata[1:0] == OP_TICK);
                    n_inj.id       = s_axis_tdata[23:2];
                    n_inj.tnew     = (s_axis_tdata[1:0] == OP_TICK) ? r_time + 1'b1 : r_time;
                    n_inj.run_slot = r_run_slot;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tail.valid) begin
                    n_status = STAT_OK;
                    n_state  = S_FIN;
                    unique case (r_op)
                        OP_REG: begin
                            if (w_tail.m_found) begin
                                n_status = STAT_DUP;
                            end else if (!w_tail.f_found) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_wr.reg_en = 1'b1;
                                w_wr.idx    = w_tail.f_idx;
                            end
                        end
                        OP_YIELD: begin
                            if (!w_tail.m_found) begin
                                n_status = STAT_UNKNOWN;
                            end else begin
                                w_wr.dl_en = 1'b1;
                                w_wr.idx   = w_tail.m_idx;
                                if (w_missed) begin
                                    n_status = STAT_MISSED;
                                end else begin
                                    w_wr.arm_en    = 1'b1;
                                    n_run_valid    = 1'b0;
                                    n_run_slot     = '0;
                                    n_run_id       = '0;
                                    n_inj.valid    = 1'b1;
                                    n_inj.tnew     = r_time;
                                    n_inj.run_slot = '0;
                                    n_state        = S_DISP;
                                end
                            end
                        end
                        OP_DEREG: begin
                            if (!w_tail.m_found) begin
                                n_status = STAT_UNKNOWN;
                            end else begin
                                w_wr.dereg_en = 1'b1;
                                w_wr.idx      = w_tail.m_idx;
                                if (r_run_valid && (r_run_slot == w_tail.m_idx)) begin
                                    n_run_valid = 1'b0;
                                    n_run_slot  = '0;
                                    n_run_id    = '0;
                                end
                            end
                        end
                        default: begin
                            n_time = w_tail.tnew;
                            if (w_tail.b_found &&
                                (!r_run_valid || (w_tail.r_per > w_tail.b_per))) begin
                                w_wr.run_en  = 1'b1;
                                w_wr.run_idx = w_tail.b_idx;
                                w_wr.rdy_en  = r_run_valid;
                                w_wr.rdy_idx = r_run_slot;
                                n_run_valid  = 1'b1;
                                n_run_slot   = w_tail.b_idx;
                                n_run_id     = w_tail.b_task;
                            end
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (w_tail.valid) begin
                    n_state = S_FIN;
                    if (w_tail.b_found) begin
                        w_wr.run_en = 1'b1;
                        w_wr.run_idx = w_tail.b_idx;
                        n_run_valid  = 1'b1;
                        n_run_slot   = w_tail.b_idx;
                        n_run_id     = w_tail.b_task;
                    end
                end
            end
            default: begin
                if (!r_ov || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inj.valid <= 1'b0;
            r_time      <= '0;
            r_run_valid <= 1'b0;
            r_run_slot  <= '0;
            r_run_id    <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inj       <= n_inj;
            r_time      <= n_time;
            r_run_valid <= n_run_valid;
            r_run_slot  <= n_run_slot;
            r_run_id    <= n_run_id;
            if ((r_state == S_FIN) && (!r_ov || m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (w_acc) begin
            r_op     <= s_axis_tdata[1:0];
            r_per_in <= s_axis_tdata[39:24];
        end
        if ((r_state == S_FIN) && (!r_ov || m_axis_tready)) begin
            r_odata <= {6'd0, r_run_id, r_run_valid, r_status};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

endmodule
`default_nettype wire

[rtl/rmts_checker.sv]
// Port-level checks for the rate-monotonic task scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rmts_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [39:0] s_axis_tdata,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);
    import rmts_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("response dropped while stalled");

    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[25:4] == '0)
        else $error("running id set with no running task");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= STAT_DUP)
        else $error("status code out of range");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not clear handshake state");

endmodule

bind rate_monotonic_task_scheduler rmts_checker u_rmts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
